// ----- rtl/p256ll_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// p256ll_pkg
// Shared types, GF(16) constants and helpers for the PHOTON-256 linear layer.
// ============================================================================
package p256ll_pkg;

    typedef logic [3:0]       t_cell;
    typedef t_cell [7:0]      t_row;     // index is the cell position
    typedef t_row  [7:0]      t_grid;    // index is the row
    typedef logic [63:0]      t_word;

    // x^4 + x + 1, low bits only
    localparam t_cell CELL_POLY = 4'h3;

    localparam t_grid FWD_MAT = '{
        '{4'd3,  4'd2,  4'd10, 4'd5,  4'd10, 4'd13, 4'd1,  4'd15},
        '{4'd14, 4'd1,  4'd1,  4'd3,  4'd10, 4'd2,  4'd2,  4'd12},
        '{4'd6,  4'd9,  4'd12, 4'd4,  4'd15, 4'd5,  4'd14, 4'd9},
        '{4'd13, 4'd14, 4'd5,  4'd14, 4'd13, 4'd9,  4'd12, 4'd15},
        '{4'd14, 4'd15, 4'd13, 4'd12, 4'd1,  4'd5,  4'd6,  4'd1},
        '{4'd9,  4'd13, 4'd4,  4'd9,  4'd13, 4'd13, 4'd4,  4'd4},
        '{4'd2,  4'd5,  4'd7,  4'd7,  4'd13, 4'd8,  4'd9,  4'd12},
        '{4'd6,  4'd5,  4'd8,  4'd2,  4'd11, 4'd2,  4'd4,  4'd2}
    };

    localparam t_grid INV_MAT = '{
        '{4'd9,  4'd3,  4'd11, 4'd4,  4'd1,  4'd12, 4'd1,  4'd2},
        '{4'd1,  4'd15, 4'd6,  4'd3,  4'd6,  4'd10, 4'd14, 4'd5},
        '{4'd11, 4'd14, 4'd14, 4'd1,  4'd6,  4'd15, 4'd15, 4'd4},
        '{4'd2,  4'd7,  4'd4,  4'd13, 4'd5,  4'd3,  4'd11, 4'd7},
        '{4'd10, 4'd11, 4'd3,  4'd11, 4'd10, 4'd7,  4'd4,  4'd5},
        '{4'd11, 4'd5,  4'd10, 4'd4,  4'd14, 4'd3,  4'd2,  4'd14},
        '{4'd7,  4'd10, 4'd13, 4'd7,  4'd10, 4'd10, 4'd13, 4'd13},
        '{4'd15, 4'd3,  4'd12, 4'd12, 4'd10, 4'd9,  4'd7,  4'd4}
    };

    // shift-and-add multiply in GF(16)
    function automatic t_cell gf16_mul(input t_cell a, input t_cell b);
        t_cell x;
        t_cell acc;
        x   = a;
        acc = '0;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            x = x[3] ? ({x[2:0], 1'b0} ^ CELL_POLY) : {x[2:0], 1'b0};
        end
        return acc;
    endfunction

    // column-wise matrix product: out[r][c] = xor_k m[r][k] * g[k][c]
    function automatic t_grid mix_grid(input t_grid g, input t_grid m);
        t_grid t;
        t_cell s;
        for (int c = 0; c < 8; c++) begin
            for (int r = 0; r < 8; r++) begin
                s = '0;
                for (int k = 0; k < 8; k++) begin
                    s = s ^ gf16_mul(g[k][c], m[r][k]);
                end
                t[r][c] = s;
            end
        end
        return t;
    endfunction

    // unpack four state words into the cell grid (row r in word r/2)
    function automatic t_grid grid_from_words(input t_word w0, input t_word w1,
                                              input t_word w2, input t_word w3);
        t_word w [4];
        t_grid g;
        w[0] = w0;
        w[1] = w1;
        w[2] = w2;
        w[3] = w3;
        for (int r = 0; r < 8; r++) begin
            for (int c = 0; c < 8; c++) begin
                g[r][c] = w[r >> 1][(((r & 1) != 0) ? 28 : 60) - 4 * c +: 4];
            end
        end
        return g;
    endfunction

    // pack the two rows of one state word
    function automatic t_word word_from_grid(input t_grid g, input int unsigned idx);
        t_word w;
        for (int c = 0; c < 8; c++) begin
            w[60 - 4 * c +: 4] = g[2 * idx][c];
            w[28 - 4 * c +: 4] = g[2 * idx + 1][c];
        end
        return w;
    endfunction

endpackage

// ----- rtl/p256ll_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// p256ll_if
// Handshake channels: input state words and transformed result words.
// ============================================================================
interface p256ll_in_if;
    import p256ll_pkg::*;

    logic  valid;
    logic  ready;
    logic  action;
    t_word state_word_0;
    t_word state_word_1;
    t_word state_word_2;
    t_word state_word_3;

    modport source (output valid, action, state_word_0, state_word_1, state_word_2,
                    state_word_3, input ready);
    modport sink   (input valid, action, state_word_0, state_word_1, state_word_2,
                    state_word_3, output ready);
endinterface

interface p256ll_out_if;
    import p256ll_pkg::*;

    logic  valid;
    logic  ready;
    t_word result_word_0;
    t_word result_word_1;
    t_word result_word_2;
    t_word result_word_3;

    modport source (output valid, result_word_0, result_word_1, result_word_2,
                    result_word_3, input ready);
    modport sink   (input valid, result_word_0, result_word_1, result_word_2,
                    result_word_3, output ready);
endinterface

// ----- rtl/p256ll_shift.sv -----
`timescale 1ns / 1ps
// ============================================================================
// p256ll_shift
// Row rotation: row r turns left (i_dir = 0) or right (i_dir = 1) by r cells.
// ============================================================================
module p256ll_shift
    import p256ll_pkg::*;
(
    input  logic  i_dir,
    input  t_grid i_grid,
    output t_grid o_grid
);

    always_comb begin
        for (int r = 0; r < 8; r++) begin
            for (int c = 0; c < 8; c++) begin
                if (i_dir) begin
                    o_grid[r][c] = i_grid[r][3'(c - r)];
                end else begin
                    o_grid[r][c] = i_grid[r][3'(c + r)];
                end
            end
        end
    end

endmodule

// ----- rtl/p256ll_mix.sv -----
`timescale 1ns / 1ps
// ============================================================================
// p256ll_mix
// Column mixing by the fixed GF(16) matrix or its inverse.
// ============================================================================
module p256ll_mix
    import p256ll_pkg::*;
(
    input  logic  i_inverse,
    input  t_grid i_grid,
    output t_grid o_grid
);

    t_grid fwd_grid;
    t_grid inv_grid;

    // constant coefficients: each product folds into a small xor net
    assign fwd_grid = mix_grid(i_grid, FWD_MAT);
    assign inv_grid = mix_grid(i_grid, INV_MAT);
    assign o_grid   = i_inverse ? inv_grid : fwd_grid;

endmodule

// ----- rtl/photon256_linear_layer_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// photon256_linear_layer_top
// PHOTON-256 linear layer (shift rows + mix columns, or the inverse).
// ============================================================================
// Usage:
//   i_in  : sink channel. One word is a 256-bit state in four 64-bit
//           state words plus the action bit (0 forward, 1 inverse).
//   o_out : source channel. One word is the transformed state, packed the
//           same way as the input.
//   Every input word yields exactly one output word, in order.
// Timing:
//   A word accepted on i_in lands in the input register; the linear layer
//   sits between that register and the output register, which presents
//   the result on o_out.
//   Throughput is one word per cycle: both registers advance together, so a
//   new word is accepted each cycle while the receiver keeps taking results.
// Stall:
//   When o_out.ready is low and a result is held, the output register holds,
//   the input register holds once it is full, and i_in.ready drops. Nothing
//   is dropped or repeated; two words can be buffered inside.
// Reset:
//   i_rst_n (synchronous, active low) clears both valid flags; data
//   registers are not reset.
// ============================================================================
module photon256_linear_layer_top
    import p256ll_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    p256ll_in_if.sink    i_in,
    p256ll_out_if.source o_out
);

    // input register
    logic  r_in_valid;
    logic  r_in_action;
    t_grid r_in_grid;

    // output register
    logic  r_out_valid;
    t_word r_out_word_0;
    t_word r_out_word_1;
    t_word r_out_word_2;
    t_word r_out_word_3;

    logic  out_load;   // output stage takes a new word
    logic  in_load;    // input stage takes a new word

    t_grid n_in_grid;
    t_grid shl_grid;
    t_grid pre_grid;
    t_grid mix_out;
    t_grid shr_grid;
    t_grid n_out_grid;

    assign out_load = !r_out_valid || o_out.ready;
    assign in_load  = !r_in_valid || out_load;

    assign i_in.ready = in_load;

    assign n_in_grid = grid_from_words(i_in.state_word_0, i_in.state_word_1,
                                       i_in.state_word_2, i_in.state_word_3);

    // forward: rotate left, then mix
    p256ll_shift u_shift_fwd (
        .i_dir  (1'b0),
        .i_grid (r_in_grid),
        .o_grid (shl_grid)
    );

    assign pre_grid = r_in_action ? r_in_grid : shl_grid;

    p256ll_mix u_mix (
        .i_inverse (r_in_action),
        .i_grid    (pre_grid),
        .o_grid    (mix_out)
    );

    // inverse: mix, then rotate right
    p256ll_shift u_shift_inv (
        .i_dir  (1'b1),
        .i_grid (mix_out),
        .o_grid (shr_grid)
    );

    assign n_out_grid = r_in_action ? shr_grid : mix_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= i_in.valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in.valid) begin
            r_in_action <= i_in.action;
            r_in_grid   <= n_in_grid;
        end
        if (out_load && r_in_valid) begin
            r_out_word_0 <= word_from_grid(n_out_grid, 0);
            r_out_word_1 <= word_from_grid(n_out_grid, 1);
            r_out_word_2 <= word_from_grid(n_out_grid, 2);
            r_out_word_3 <= word_from_grid(n_out_grid, 3);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.result_word_0 = r_out_word_0;
    assign o_out.result_word_1 = r_out_word_1;
    assign o_out.result_word_2 = r_out_word_2;
    assign o_out.result_word_3 = r_out_word_3;

endmodule

// ----- sim/photon256_linear_layer_top_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// photon256_linear_layer_top_tb
// Self-checking bench for the PHOTON-256 linear layer (shift rows + mix
// columns, and the inverse pair). Every accepted state word is run through a
// local bit-level model of the layer. Each result word is compared with the
// oldest prediction, one state word at a time.
// ============================================================================
module photon256_linear_layer_top_tb;
    import p256ll_pkg::*;

    // Whole state as one vector: row r sits at bits 255-32r downto 224-32r,
    // cell c of that row at 31-4c downto 28-4c within the row.
    typedef logic [255:0] t_state256;

    localparam int          WATCHDOG_LIMIT = 2000;  // cycles with no word moved
    localparam int          SETTLE_CYCLES  = 8;     // well past the pipeline depth
    localparam int          RANDOM_ITEMS   = 440;
    localparam int          FULL_RATE_ITEMS = 100;
    localparam logic [3:0]  GF_REDUCE      = 4'h3;  // x^4 + x + 1, low bits
    localparam logic        ACT_FORWARD    = 1'b0;
    localparam logic        ACT_INVERSE    = 1'b1;

    logic i_clk;
    logic i_rst_n;

    p256ll_in_if  in_ch ();
    p256ll_out_if out_ch ();

    photon256_linear_layer_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_state256 pending_results[$];  // predicted results, oldest first
    int        err_count;
    int        idle_cycles;
    logic      in_gaps;             // random idle bursts on the input side
    logic      out_stalls;          // random stall bursts on the output side

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Local model of the layer
    // ------------------------------------------------------------------------

    // GF(16) product, shift-and-add with reduction
    function automatic logic [3:0] gf_mult(input logic [3:0] a, input logic [3:0] b);
        logic [3:0] x;
        logic [3:0] p;
        x = a;
        p = 4'h0;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) begin
                p = p ^ x;
            end
            x = {x[2:0], 1'b0} ^ (x[3] ? GF_REDUCE : 4'h0);
        end
        return p;
    endfunction

    // One matrix row, coefficient k in bits 31-4k downto 28-4k
    function automatic logic [31:0] coef_row(input logic inv, input int r);
        logic [3:0] sel;
        logic [31:0] row;
        sel = {inv, r[2:0]};
        case (sel)
            4'h0: row = 32'h242B2856;
            4'h1: row = 32'hC98D7752;
            4'h2: row = 32'h44DD94D9;
            4'h3: row = 32'h1651CDFE;
            4'h4: row = 32'hFC9DE5ED;
            4'h5: row = 32'h9E5F4C96;
            4'h6: row = 32'hC22A311E;
            4'h7: row = 32'hF1DA5A23;
            4'h8: row = 32'h479ACC3F;
            4'h9: row = 32'hDDAA7DA7;
            4'hA: row = 32'hE23E4A5B;
            4'hB: row = 32'h547AB3BA;
            4'hC: row = 32'h7B35D472;
            4'hD: row = 32'h4FF61EEB;
            4'hE: row = 32'h5EA636F1;
            default: row = 32'h21C14B39;
        endcase
        return row;
    endfunction

    // Row r turned left (or right) by r cells
    function automatic t_state256 rotate_rows(input t_state256 st, input logic right);
        t_state256 t;
        int src;
        for (int r = 0; r < 8; r++) begin
            for (int c = 0; c < 8; c++) begin
                src = right ? ((c + 8 - r) & 7) : ((c + r) & 7);
                t[255 - 32 * r - 4 * c -: 4] = st[255 - 32 * r - 4 * src -: 4];
            end
        end
        return t;
    endfunction

    // Each column times the fixed (or inverse) matrix
    function automatic t_state256 mix_columns(input t_state256 st, input logic inv);
        t_state256 t;
        logic [31:0] m;
        logic [3:0] acc;
        for (int r = 0; r < 8; r++) begin
            m = coef_row(inv, r);
            for (int c = 0; c < 8; c++) begin
                acc = 4'h0;
                for (int k = 0; k < 8; k++) begin
                    acc = acc ^ gf_mult(st[255 - 32 * k - 4 * c -: 4], m[31 - 4 * k -: 4]);
                end
                t[255 - 32 * r - 4 * c -: 4] = acc;
            end
        end
        return t;
    endfunction

    function automatic t_state256 photon_linear(input logic act, input t_state256 st);
        if (act == ACT_FORWARD) begin
            return mix_columns(rotate_rows(st, 1'b0), 1'b0);
        end else begin
            return rotate_rows(mix_columns(st, 1'b1), 1'b1);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_state256 rand_state();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    // a handful of non-zero cells on a zero background
    function automatic t_state256 sparse_state();
        t_state256 st;
        int idx;
        st = '0;
        for (int j = 0; j < int'($urandom_range(1, 3)); j++) begin
            idx = $urandom_range(0, 63);
            st[255 - 4 * idx -: 4] = 4'($urandom_range(1, 15));
        end
        return st;
    endfunction

    // Called at a rising edge; returns at the edge that accepts the word.
    // valid stays high afterwards so back-to-back words need no toggle.
    task automatic send_state(input logic act, input t_state256 st);
        if (in_gaps && $urandom_range(0, 9) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.action       <= act;
        in_ch.state_word_0 <= st[255:192];
        in_ch.state_word_1 <= st[191:128];
        in_ch.state_word_2 <= st[127:64];
        in_ch.state_word_3 <= st[63:0];
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        pending_results.push_back(photon_linear(act, st));
    endtask

    // Hold the input until every predicted result has come back
    task automatic pause_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Edge patterns for both directions, plus forward/inverse round trips
    task automatic test_directed_cases();
        t_state256 st;
        t_state256 col;
        in_gaps    = 1'b1;
        out_stalls = 1'b1;
        send_state(ACT_FORWARD, '0);
        send_state(ACT_INVERSE, '0);
        send_state(ACT_FORWARD, '1);
        send_state(ACT_INVERSE, '1);
        st = {4{64'h0123456789ABCDEF}};
        send_state(ACT_FORWARD, st);
        send_state(ACT_INVERSE, st);
        // lone cell in the top-left and bottom-right corners
        send_state(ACT_FORWARD, {4'h1, 252'h0});
        send_state(ACT_INVERSE, {4'h1, 252'h0});
        send_state(ACT_FORWARD, {252'h0, 4'hF});
        send_state(ACT_INVERSE, {252'h0, 4'hF});
        // full row 3, full column 5
        send_state(ACT_FORWARD, {96'h0, 32'hFFFFFFFF, 128'h0});
        col = '0;
        for (int r = 0; r < 8; r++) begin
            col[255 - 32 * r - 20 -: 4] = 4'hF;
        end
        send_state(ACT_INVERSE, col);
        send_state(ACT_FORWARD, {64{4'h5}});
        send_state(ACT_INVERSE, {64{4'hA}});
        // round trips: forward then inverse, inverse then forward
        st = rand_state();
        send_state(ACT_FORWARD, st);
        send_state(ACT_INVERSE, photon_linear(ACT_FORWARD, st));
        st = rand_state();
        send_state(ACT_INVERSE, st);
        send_state(ACT_FORWARD, photon_linear(ACT_INVERSE, st));
    endtask

    // Random states with idle and stall bursts; drains once halfway through
    task automatic test_random_states(input int n_items);
        t_state256 st;
        int kind;
        in_gaps    = 1'b1;
        out_stalls = 1'b1;
        for (int i = 0; i < n_items; i++) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                st = rand_state();
                send_state(ACT_FORWARD, st);
                send_state(ACT_INVERSE, photon_linear(ACT_FORWARD, st));
            end else if (kind <= 2) begin
                send_state(1'($urandom_range(0, 1)), sparse_state());
            end else begin
                send_state(1'($urandom_range(0, 1)), rand_state());
            end
            if (i == n_items / 2) begin
                pause_until_drained();
            end
        end
    endtask

    // Both sides always willing: drives the one word per cycle throughput path
    task automatic test_full_rate(input int n_items);
        in_gaps    = 1'b0;
        out_stalls = 1'b0;
        for (int i = 0; i < n_items; i++) begin
            send_state(1'($urandom_range(0, 1)), rand_state());
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall driver, checker, watchdog
    // ------------------------------------------------------------------------

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_stalls && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    initial begin
        t_state256 got;
        t_state256 want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got = {out_ch.result_word_0, out_ch.result_word_1,
                       out_ch.result_word_2, out_ch.result_word_3};
                if (pending_results.size() == 0) begin
                    $error("result word with no state pending: %h", got);
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    for (int i = 0; i < 4; i++) begin
                        if (got[255 - 64 * i -: 64] !== want[255 - 64 * i -: 64]) begin
                            $error("result_word_%0d: expected %h, got %h", i,
                                   want[255 - 64 * i -: 64], got[255 - 64 * i -: 64]);
                            err_count++;
                        end
                    end
                end
            end
        end
    end

    // Ends the run if no word moves on either side for too long
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        err_count          = 0;
        in_gaps            = 1'b0;
        out_stalls         = 1'b0;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.action       <= ACT_FORWARD;
        in_ch.state_word_0 <= '0;
        in_ch.state_word_1 <= '0;
        in_ch.state_word_2 <= '0;
        in_ch.state_word_3 <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_states(RANDOM_ITEMS);
        test_full_rate(FULL_RATE_ITEMS);

        // drain, then give the pipeline time to show any stray word
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
